// ===== sv/trpd_pkg.sv =====
package trpd_pkg;

    localparam int unsigned LenW  = 24;
    localparam int unsigned ByteW = 8;

    // request codes
    localparam logic [1:0] REQ_DATA   = 2'd0;
    localparam logic [1:0] REQ_END    = 2'd1;
    localparam logic [1:0] REQ_REWIND = 2'd2;

    // pulse levels
    localparam logic [1:0] LVL_LOW  = 2'd0;
    localparam logic [1:0] LVL_HIGH = 2'd1;
    localparam logic [1:0] LVL_ZERO = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_EXT_LEN_EN       = 2'd0;
    localparam logic [1:0] CFG_HALF_WAVE_MODE   = 2'd1;
    localparam logic [1:0] CFG_END_PULSE_LENGTH = 2'd2;

    localparam logic [LenW-1:0] END_LEN_RESET = 24'd1970496;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [ByteW-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      pulse_level;
        logic [LenW-1:0] pulse_length;
        logic            last_of_run;
    } t_out_item;

    typedef struct packed {
        logic            ext_len_en;
        logic            half_wave_mode;
        logic [LenW-1:0] end_pulse_length;
    } t_cfg;

    // pulses for one input: a single pulse, or a low-high pair
    typedef struct packed {
        logic            pair;
        logic [1:0]      level;
        logic [LenW-1:0] length;
    } t_job;

    typedef struct packed {
        logic second_pending;
    } t_emit_status;

endpackage

// ===== sv/trpd_decode.sv =====
module trpd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  trpd_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  trpd_pkg::t_in_item i_in,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output trpd_pkg::t_job    o_job
);
    import trpd_pkg::*;

    logic            r_level_is_high, n_level_is_high;
    logic            r_ended, n_ended;
    logic [1:0]      r_ext_left, n_ext_left;
    logic [LenW-1:0] r_ext_len, n_ext_len;
    logic            r_job_valid;
    t_job            r_job, n_job;
    logic            gen;
    logic            give;
    logic [LenW-1:0] give_len;
    logic [LenW-1:0] gathered;
    logic            accept;

    assign o_in_ready = !r_job_valid || i_job_ready;
    assign accept     = i_in_valid && o_in_ready;

    // place the next little-endian byte of a three-byte length
    always_comb begin
        gathered = r_ext_len;
        unique case (r_ext_left)
            2'd3:    gathered[7:0]   = r_ext_len[7:0]   | i_in.data_byte;
            2'd2:    gathered[15:8]  = r_ext_len[15:8]  | i_in.data_byte;
            2'd1:    gathered[23:16] = r_ext_len[23:16] | i_in.data_byte;
            default: gathered = r_ext_len;
        endcase
    end

    always_comb begin
        n_level_is_high = r_level_is_high;
        n_ended         = r_ended;
        n_ext_left      = r_ext_left;
        n_ext_len       = r_ext_len;
        n_job           = r_job;
        gen             = 1'b0;
        give            = 1'b0;
        give_len        = {{(LenW - ByteW - 3){1'b0}}, i_in.data_byte, 3'b000};

        priority if (i_in.req_type == REQ_REWIND) begin
            n_level_is_high = 1'b1;
            n_ended         = 1'b0;
            n_ext_left      = 2'd0;
            n_ext_len       = '0;
        end else if (r_ended) begin
            // everything but a rewind is dropped after end of data
        end else if (i_in.req_type == REQ_END) begin
            n_ended      = 1'b1;
            n_ext_left   = 2'd0;
            n_ext_len    = '0;
            gen          = 1'b1;
            n_job.pair   = 1'b0;
            n_job.level  = LVL_ZERO;
            n_job.length = i_cfg.end_pulse_length;
        end else if (i_in.req_type == REQ_DATA) begin
            priority if (r_ext_left != 2'd0) begin
                n_ext_len  = gathered;
                n_ext_left = r_ext_left - 2'd1;
                give       = (r_ext_left == 2'd1);
                give_len   = gathered;
            end else if (i_cfg.ext_len_en && i_in.data_byte == '0) begin
                n_ext_left = 2'd3;
                n_ext_len  = '0;
            end else begin
                give = 1'b1;
            end
        end else begin
            // unused request code is ignored
        end

        if (give) begin
            gen          = 1'b1;
            n_job.length = give_len;
            if (i_cfg.half_wave_mode) begin
                n_job.pair      = 1'b0;
                n_job.level     = r_level_is_high ? LVL_LOW : LVL_HIGH;
                n_level_is_high = !r_level_is_high;
            end else begin
                n_job.pair      = 1'b1;
                n_job.level     = LVL_LOW;
                n_level_is_high = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_is_high <= 1'b1;
            r_ended         <= 1'b0;
            r_ext_left      <= 2'd0;
            r_ext_len       <= '0;
            r_job_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_level_is_high <= n_level_is_high;
                r_ended         <= n_ended;
                r_ext_left      <= n_ext_left;
                r_ext_len       <= n_ext_len;
                r_job_valid     <= gen;
            end else if (i_job_ready) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && gen) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

endmodule

// ===== sv/trpd_emit.sv =====
module trpd_emit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    output logic                   o_job_ready,
    input  trpd_pkg::t_job         i_job,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output trpd_pkg::t_out_item    o_out,
    output trpd_pkg::t_emit_status o_status
);
    import trpd_pkg::*;

    logic      r_out_valid;
    logic      r_pend;
    t_out_item r_out;
    logic      out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_job_ready = out_free && !r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else begin
                r_out_valid <= i_job_valid;
                r_pend      <= i_job_valid && i_job.pair;
            end
        end
    end

    // second pulse of a pair keeps the length, goes high and closes the run
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend) begin
                r_out.pulse_level <= LVL_HIGH;
                r_out.last_of_run <= 1'b1;
            end else if (i_job_valid) begin
                r_out.pulse_level  <= i_job.level;
                r_out.pulse_length <= i_job.length;
                r_out.last_of_run  <= !i_job.pair;
            end
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out                   = r_out;
    assign o_status.second_pending = r_pend;

endmodule

// ===== sv/tape_raw_pulse_decoder.sv =====
// Raw tape pulse decoder: takes tape body bytes, end-of-data and rewind requests on the
// input channel and gives timed pulses (level, length in ticks, last-of-run flag) on the
// output channel through the decode and output registers. A full-wave pair holds back
// the next job while its high pulse waits; a half-wave byte, end or rewind flows one
// item per cycle unless the output stalls. A three-byte length gives pulses only on its
// last byte; rewinds and anything after end of data give none. The user must write the
// configuration port only while the block is idle (unchecked). Index three is ignored.
module tape_raw_pulse_decoder (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [23:0]             i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  trpd_pkg::t_in_item      i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output trpd_pkg::t_out_item     o_out
);
    import trpd_pkg::*;

    t_cfg         r_cfg;
    logic         job_valid;
    logic         job_ready;
    t_job         job;
    t_emit_status emit_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ext_len_en       <= 1'b0;
            r_cfg.half_wave_mode   <= 1'b0;
            r_cfg.end_pulse_length <= END_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXT_LEN_EN:       r_cfg.ext_len_en       <= i_cfg_wdata[0];
                CFG_HALF_WAVE_MODE:   r_cfg.half_wave_mode   <= i_cfg_wdata[0];
                CFG_END_PULSE_LENGTH: r_cfg.end_pulse_length <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    trpd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    trpd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_status    (emit_status)
    );

`ifndef SYNTH
    // a pending high pulse always sits behind the low one on the output
    a_pend_behind_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_status.second_pending |-> o_out_valid && o_out.pulse_level == LVL_LOW
            && !o_out.last_of_run)
        else $error("second pulse pending without a low pulse on the output");

    // only the low half of a pair leaves without closing its run
    a_open_run_is_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last_of_run |-> o_out.pulse_level == LVL_LOW)
        else $error("non-final pulse that is not low");

    // the pair's high pulse follows its low pulse with the same length
    a_pair_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.last_of_run |=>
            o_out_valid && o_out.pulse_level == LVL_HIGH && o_out.last_of_run
            && o_out.pulse_length == $past(o_out.pulse_length))
        else $error("high pulse of a pair missing or altered");

    // the end pulse is a run of its own
    a_end_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.pulse_level == LVL_ZERO |-> o_out.last_of_run)
        else $error("end pulse not marked last of run");
`endif

endmodule

// ===== verif/tape_raw_pulse_decoder_tb.sv =====
module tape_raw_pulse_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trpd_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] CFG_NONE   = 2'd3;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SETTLE_TICKS = 8;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_cfg_we    = 1'b0;
    logic [1:0]      i_cfg_index = CFG_EXT_LEN_EN;
    logic [23:0]     i_cfg_wdata = '0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_ready;
    t_in_item        i_in        = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    t_out_item       o_out;

    tape_raw_pulse_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #6 i_clk = ~i_clk;

    // decoder mirror: configuration and state
    logic            cfg_layout   = 1'b0;
    logic            cfg_half     = 1'b0;
    logic [LenW-1:0] cfg_end_len  = END_LEN_RESET;
    logic            level_hi     = 1'b1;
    logic            tape_ended   = 1'b0;
    logic [1:0]      ext_left     = 2'd0;
    logic [LenW-1:0] ext_len      = '0;

    t_out_item       expected_pulses[$];
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count    = 0;
    bit              in_idle_en     = 1'b0;
    bit              out_idle_en    = 1'b0;
    int unsigned     stall_left     = 0;

    function automatic void queue_pulse(logic [1:0] lvl, logic [LenW-1:0] len, logic last);
        t_out_item p;
        p.pulse_level  = lvl;
        p.pulse_length = len;
        p.last_of_run  = last;
        expected_pulses.push_back(p);
    endfunction

    function automatic void emit_length(logic [LenW-1:0] len);
        if (cfg_half) begin
            queue_pulse(level_hi ? LVL_LOW : LVL_HIGH, len, 1'b1);
            level_hi = ~level_hi;
        end else begin
            queue_pulse(LVL_LOW, len, 1'b0);
            queue_pulse(LVL_HIGH, len, 1'b1);
            level_hi = 1'b1;
        end
    endfunction

    function automatic void predict_pulses(t_in_item it);
        if (it.req_type == REQ_REWIND) begin
            level_hi   = 1'b1;
            tape_ended = 1'b0;
            ext_left   = 2'd0;
            ext_len    = '0;
            return;
        end
        if (it.req_type == REQ_UNUSED || tape_ended)
            return;
        if (it.req_type == REQ_END) begin
            tape_ended = 1'b1;
            ext_left   = 2'd0;
            ext_len    = '0;
            queue_pulse(LVL_ZERO, cfg_end_len, 1'b1);
            return;
        end
        if (ext_left != 2'd0) begin
            // little-endian: first byte lands lowest
            ext_len  = ext_len | (LenW'(it.data_byte) << (8 * (3 - int'(ext_left))));
            ext_left = ext_left - 2'd1;
            if (ext_left == 2'd0)
                emit_length(ext_len);
            return;
        end
        if (cfg_layout && it.data_byte == 8'd0) begin
            ext_left = 2'd3;
            ext_len  = '0;
            return;
        end
        emit_length({13'd0, it.data_byte, 3'd0});
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_tape_item(input logic [1:0] req, input logic [7:0] data);
        t_in_item it;
        int unsigned gap;
        it.req_type  = req;
        it.data_byte = data;
        if (in_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pulses(it);
    endtask

    // stop sending and let the decoder drain before touching registers
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_pulses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_EXT_LEN_EN:       cfg_layout  = val[0];
            CFG_HALF_WAVE_MODE:   cfg_half    = val[0];
            CFG_END_PULSE_LENGTH: cfg_end_len = val;
            default: ;
        endcase
    endtask

    // reset config: old layout, full wave, reset end length
    task automatic test_short_lengths();
        send_tape_item(REQ_DATA, 8'h00);
        send_tape_item(REQ_DATA, 8'hFF);
        send_tape_item(REQ_DATA, 8'h01);
        send_tape_item(REQ_END, 8'hA5);
        send_tape_item(REQ_DATA, 8'h10);
        send_tape_item(REQ_END, 8'h00);
        send_tape_item(REQ_UNUSED, 8'h5A);
        send_tape_item(REQ_REWIND, 8'hC3);
    endtask

    task automatic test_half_wave();
        wait_idle();
        write_reg(CFG_HALF_WAVE_MODE, 24'd1);
        write_reg(CFG_END_PULSE_LENGTH, 24'd0);
        write_reg(CFG_NONE, 24'hFFFFFF);
        send_tape_item(REQ_DATA, 8'hAA);
        // full wave in between puts the level back to high
        wait_idle();
        write_reg(CFG_HALF_WAVE_MODE, 24'd0);
        send_tape_item(REQ_DATA, 8'h55);
        wait_idle();
        write_reg(CFG_HALF_WAVE_MODE, 24'd1);
        send_tape_item(REQ_DATA, 8'h01);
        send_tape_item(REQ_DATA, 8'h02);
        send_tape_item(REQ_END, 8'h00);
        send_tape_item(REQ_REWIND, 8'h00);
    endtask

    task automatic test_extended_length();
        wait_idle();
        write_reg(CFG_EXT_LEN_EN, 24'd1);
        write_reg(CFG_HALF_WAVE_MODE, 24'd0);
        write_reg(CFG_END_PULSE_LENGTH, 24'hFFFFFF);
        send_tape_item(REQ_DATA, 8'h00);
        send_tape_item(REQ_DATA, 8'hFF);
        send_tape_item(REQ_DATA, 8'hFF);
        send_tape_item(REQ_DATA, 8'hFF);
        // zero length goes out unchanged
        send_tape_item(REQ_DATA, 8'h00);
        send_tape_item(REQ_DATA, 8'h00);
        send_tape_item(REQ_DATA, 8'h00);
        send_tape_item(REQ_DATA, 8'h00);
        // end cuts a partial length
        send_tape_item(REQ_DATA, 8'h00);
        send_tape_item(REQ_DATA, 8'h12);
        send_tape_item(REQ_END, 8'h00);
        send_tape_item(REQ_REWIND, 8'h00);
        // layout switched off with bytes still owed
        send_tape_item(REQ_DATA, 8'h00);
        send_tape_item(REQ_DATA, 8'h34);
        wait_idle();
        write_reg(CFG_EXT_LEN_EN, 24'd0);
        send_tape_item(REQ_DATA, 8'h56);
        send_tape_item(REQ_DATA, 8'h78);
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input bit idle,
                                       input logic layout, input logic half,
                                       input logic [23:0] end_len);
        int unsigned counted;
        int unsigned pick;
        logic [1:0]  req;
        logic [7:0]  data;
        wait_idle();
        in_idle_en  = idle;
        out_idle_en = idle;
        write_reg(CFG_EXT_LEN_EN, {23'd0, layout});
        write_reg(CFG_HALF_WAVE_MODE, {23'd0, half});
        write_reg(CFG_END_PULSE_LENGTH, end_len);
        counted = 0;
        while (counted < n_items) begin
            pick = $urandom_range(0, 99);
            if (tape_ended && pick < 60)
                req = REQ_REWIND;
            else if (pick < 84)
                req = REQ_DATA;
            else if (pick < 91)
                req = REQ_END;
            else if (pick < 96)
                req = REQ_REWIND;
            else
                req = REQ_UNUSED;
            data = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            if (!(req == REQ_UNUSED || (tape_ended && req != REQ_REWIND)))
                counted++;
            send_tape_item(req, data);
        end
    endtask

    always @(negedge i_clk) begin
        if (!out_idle_en) begin
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  = stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  = $urandom_range(1, 18) - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_pulses
        t_out_item got;
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out;
            if (expected_pulses.size() == 0) begin
                report_mismatch("unexpected pulse", 32'(got), 32'd0);
            end else begin
                want = expected_pulses.pop_front();
                if (got.pulse_level !== want.pulse_level)
                    report_mismatch("pulse_level", 32'(got.pulse_level),
                                    32'(want.pulse_level));
                if (got.pulse_length !== want.pulse_length)
                    report_mismatch("pulse_length", 32'(got.pulse_length),
                                    32'(want.pulse_length));
                if (got.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 32'(got.last_of_run),
                                    32'(want.last_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d pulses outstanding", expected_pulses.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        test_short_lengths();
        test_half_wave();
        test_extended_length();

        test_random_traffic(130, 1'b1, 1'b1, 1'b0, 24'd0);
        test_random_traffic(130, 1'b1, 1'b0, 1'b1, 24'hFFFFFF);
        test_random_traffic(130, 1'b1, 1'b1, 1'b1, 24'($urandom));
        test_random_traffic(130, $urandom_range(0, 3) != 0, 1'b0, 1'b0, END_LEN_RESET);
        test_random_traffic(130, $urandom_range(0, 3) != 0, 1'($urandom),
                            1'($urandom), 24'($urandom));
        test_random_traffic(130, 1'b1, 1'b1, 1'($urandom), 24'($urandom));
        // final stretch at full rate
        test_random_traffic(120, 1'b0, 1'b1, 1'($urandom), 24'($urandom));

        wait_idle();
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
